[src/m3h_pkg.sv]
`default_nettype none
package m3h_pkg;

    localparam logic [31:0] MIX_C1  = 32'hcc9e2d51;
    localparam logic [31:0] MIX_C2  = 32'h1b873593;
    localparam logic [31:0] MIX_ADD = 32'he6546b64;
    localparam logic [31:0] FIN_M1  = 32'h85ebca6b;
    localparam logic [31:0] FIN_M2  = 32'hc2b2ae35;

    localparam logic [2:0] FULL_COUNT = 3'd4;

    typedef struct packed {
        logic accept;
        logic load_seed;
        logic mul1;
        logic mul2;
        logic mix;
        logic fin1;
        logic fin2;
        logic out_load;
    } m3h_cmd_t;

    typedef struct packed {
        logic last;
    } m3h_status_t;

    // bytes beyond the count are dropped
    function automatic logic [31:0] tail_mask(input logic [2:0] cnt);
        logic [31:0] m;
        begin
            case (cnt)
                3'd0:    m = 32'h0000_0000;
                3'd1:    m = 32'h0000_00ff;
                3'd2:    m = 32'h0000_ffff;
                3'd3:    m = 32'h00ff_ffff;
                default: m = 32'hffff_ffff;
            endcase
            return m;
        end
    endfunction

endpackage
`default_nettype wire

[src/m3h_in_if.sv]
`default_nettype none
interface m3h_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] data_word;
    logic [2:0]  byte_count;
    logic        last_word;

    modport source (output valid, output data_word, output byte_count, output last_word,
                    input ready);
    modport sink   (input valid, input data_word, input byte_count, input last_word,
                    output ready);
endinterface
`default_nettype wire

[src/m3h_out_if.sv]
`default_nettype none
interface m3h_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] hash_value;

    modport source (output valid, output hash_value, input ready);
    modport sink   (input valid, input hash_value, output ready);
endinterface
`default_nettype wire

[src/m3h_cfg_if.sv]
`default_nettype none
interface m3h_cfg_if;
    logic        valid;
    logic        ready;
    logic [31:0] seed;

    modport source (output valid, output seed, input ready);
    modport sink   (input valid, input seed, output ready);
endinterface
`default_nettype wire

[src/m3h_ctrl.sv]
`default_nettype none
module m3h_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output m3h_pkg::m3h_cmd_t        cmd,
    input  wire m3h_pkg::m3h_status_t status
);
    import m3h_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL1,
        ST_MUL2,
        ST_MIX,
        ST_FIN1,
        ST_FIN2,
        ST_FIN3
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   mid_reg;
    logic   mid_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        mid_next       = mid_reg;
        cmd.load_seed  = !mid_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = ST_MUL1;
                end
            end
            ST_MUL1:
            begin
                cmd.mul1   = 1'b1;
                state_next = ST_MUL2;
            end
            ST_MUL2:
            begin
                cmd.mul2   = 1'b1;
                state_next = ST_MIX;
            end
            ST_MIX:
            begin
                cmd.mix    = 1'b1;
                mid_next   = !status.last;
                state_next = status.last ? ST_FIN1 : ST_IDLE;
            end
            ST_FIN1:
            begin
                cmd.fin1   = 1'b1;
                state_next = ST_FIN2;
            end
            ST_FIN2:
            begin
                cmd.fin2   = 1'b1;
                state_next = ST_FIN3;
            end
            ST_FIN3:
            begin
                // wait here while the previous hash is still unread
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            mid_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mid_reg       <= mid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule
`default_nettype wire

[src/m3h_dp.sv]
`default_nettype none
module m3h_dp (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_we,
    input  wire logic [31:0]       cfg_seed,
    input  wire logic [31:0]       data_word,
    input  wire logic [2:0]        byte_count,
    input  wire logic              last_word,
    input  wire m3h_pkg::m3h_cmd_t cmd,
    output m3h_pkg::m3h_status_t   status,
    output logic [31:0]            hash_value
);
    import m3h_pkg::*;

    logic [31:0] seed_reg;
    logic [31:0] k_reg;
    logic [31:0] h_reg;
    logic [31:0] total_reg;
    logic [2:0]  cnt_reg;
    logic        last_reg;
    logic [31:0] hash_reg;

    logic [2:0]  cnt_eff;
    logic [31:0] k_rot;
    logic [31:0] hk;
    logic [31:0] hk_rot;
    logic [31:0] h_mixed;
    logic [31:0] fin_x;
    logic [31:0] fin_a;
    logic [31:0] fin_b;
    logic [31:0] fin_c;

    always_comb
    begin
        if (!last_word || byte_count > FULL_COUNT)
            cnt_eff = FULL_COUNT;
        else
            cnt_eff = byte_count;

        k_rot  = {k_reg[16:0], k_reg[31:17]};
        hk     = h_reg ^ k_reg;
        hk_rot = {hk[18:0], hk[31:19]};

        if (cnt_reg == FULL_COUNT)
            h_mixed = {hk_rot[29:0], 2'b00} + hk_rot + MIX_ADD;
        else if (cnt_reg != 3'd0)
            h_mixed = hk;
        else
            h_mixed = h_reg;

        fin_x = h_reg ^ total_reg;
        fin_a = fin_x ^ {16'd0, fin_x[31:16]};
        fin_b = h_reg ^ {13'd0, h_reg[31:13]};
        fin_c = h_reg ^ {16'd0, h_reg[31:16]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            seed_reg <= '0;
        else if (cfg_we)
            seed_reg <= cfg_seed;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            k_reg    <= data_word & tail_mask(cnt_eff);
            cnt_reg  <= cnt_eff;
            last_reg <= last_word;
            if (cmd.load_seed)
            begin
                h_reg     <= seed_reg;
                total_reg <= '0;
            end
        end
        if (cmd.mul1)
            k_reg <= k_reg * MIX_C1;
        if (cmd.mul2)
            k_reg <= k_rot * MIX_C2;
        if (cmd.mix)
        begin
            h_reg     <= h_mixed;
            total_reg <= total_reg + {29'd0, cnt_reg};
        end
        if (cmd.fin1)
            h_reg <= fin_a * FIN_M1;
        if (cmd.fin2)
            h_reg <= fin_b * FIN_M2;
        if (cmd.out_load)
        begin
            h_reg    <= fin_c;
            hash_reg <= fin_c;
        end
    end

    assign status.last = last_reg;
    assign hash_value  = hash_reg;

endmodule
`default_nettype wire

[src/murmur3_32_stream_hash_top.sv]
// MurmurHash3 x86_32 over a stream of little-endian 32-bit words. The
// controller steps one datapath through the two scramble multiplies and the
// mix for each word, one 32x32 multiply per cycle, before the next word can be
// taken; after the last word of a message it goes on through the two finaliser
// multiplies and then registers the hash at the output, waiting first while
// the previous hash is still unread. The next word can be taken once the hash
// is registered. The hash waits in an output register so the next message can
// start meanwhile. The seed is latched at the first word of each message;
// write it only while no message is open.
`default_nettype none
module murmur3_32_stream_hash_top (
    input  wire logic clk,
    input  wire logic rst_n,
    m3h_cfg_if.sink   cfg,
    m3h_in_if.sink    in_ch,
    m3h_out_if.source out_ch
);
    import m3h_pkg::*;

    m3h_cmd_t    cmd;
    m3h_status_t status;

    assign cfg.ready = 1'b1;

    m3h_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .cmd       (cmd),
        .status    (status)
    );

    m3h_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg.valid),
        .cfg_seed   (cfg.seed),
        .data_word  (in_ch.data_word),
        .byte_count (in_ch.byte_count),
        .last_word  (in_ch.last_word),
        .cmd        (cmd),
        .status     (status),
        .hash_value (out_ch.hash_value)
    );

endmodule
`default_nettype wire

[src/m3h_checker.sv]
`default_nettype none
module m3h_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [31:0] hash_value
);
    logic in_acc;

    assign in_acc = in_valid && in_ready;

    // one word in flight at a time
    assert property (@(posedge clk) disable iff (!rst_n) in_acc |=> !in_ready)
        else $error("input taken while a word is in flight");

    // a hash never appears right after a word is taken
    assert property (@(posedge clk) disable iff (!rst_n) in_acc |=> !$rose(out_valid))
        else $error("hash appeared without finalisation");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("hash dropped while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(hash_value))
        else $error("hash changed while stalled");

endmodule

bind murmur3_32_stream_hash_top m3h_checker u_m3h_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .hash_value (out_ch.hash_value)
);
`default_nettype wire
